[sv/q4dp_pkg.sv]
// Shared types, constants and helpers for the int4 block dot product.
// No dependencies; every other file in sv/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package q4dp_pkg;

  // Fixed-point formats
  localparam int SCALE_FRAC_BITS = 12;
  localparam int SUM_FRAC_BITS   = 24;
  localparam int TERM_SHIFT      = SUM_FRAC_BITS - 2 * SCALE_FRAC_BITS;
  localparam int TERM_SHL        = (TERM_SHIFT > 0) ? TERM_SHIFT : 0;
  localparam int TERM_SHR        = (TERM_SHIFT < 0) ? -TERM_SHIFT : 0;

  // Block geometry
  localparam int NIB_W          = 4;
  localparam int WORD_W         = 64;
  localparam int NUM_ELEMS      = 2 * WORD_W / NIB_W;          // 32 values per block
  localparam int NUM_LANES      = 8;
  localparam int ELEMS_PER_LANE = NUM_ELEMS / NUM_LANES;       // 4
  localparam int LANE_IN_W      = ELEMS_PER_LANE * NIB_W;      // 16

  // Datapath widths
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = 8;   // (-8..7)^2 products: -56..64
  localparam int LANE_SUM_W = 10;  // four products: -224..256
  localparam int DOT_W      = 13;  // 32 products: -1792..2048
  localparam int SP_W       = 2 * SCALE_W;
  localparam int RAW_W      = SP_W + DOT_W;
  localparam int ACC_W      = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic signed [LANE_SUM_W-1:0] lane_sum_t;
  typedef lane_sum_t [NUM_LANES-1:0]    lane_sum_vec_t;

  // Input transaction
  typedef struct packed {
    logic signed [SCALE_W-1:0] x_scale;
    logic signed [SCALE_W-1:0] y_scale;
    logic [WORD_W-1:0]         x_nibbles_lo;
    logic [WORD_W-1:0]         x_nibbles_hi;
    logic [WORD_W-1:0]         y_nibbles_lo;
    logic [WORD_W-1:0]         y_nibbles_hi;
    logic                      last_block;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [ACC_W-1:0] dot_sum;
    logic                    saturated;
  } out_item_t;

  // Per-stage control carried alongside the datapath
  typedef struct packed {
    logic vld;
    logic last;
  } stg_ctrl_t;

  // Bring a raw term (2*SCALE_FRAC_BITS fraction bits) to SUM_FRAC_BITS.
  // Arithmetic right shift rounds toward minus infinity.
  function automatic logic signed [ACC_W-1:0] align_term(input logic signed [RAW_W-1:0] raw);
    logic signed [ACC_W-1:0] ext;
    ext = ACC_W'(raw);
    return (ext <<< TERM_SHL) >>> TERM_SHR;
  endfunction

endpackage

`default_nettype wire

[sv/q4dp_lane.sv]
// One lane: products of four offset nibble pairs, summed and registered.
// Depends on q4dp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_lane
  import q4dp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire logic [LANE_IN_W-1:0] x_nibs,
  input  wire logic [LANE_IN_W-1:0] y_nibs,
  output lane_sum_t                 lane_sum_r
);

  lane_sum_t lane_sum_nxt;

  // Nibble minus 8 is the nibble with its top bit flipped, read as signed
  always_comb begin
    logic signed [NIB_W-1:0]  xv;
    logic signed [NIB_W-1:0]  yv;
    logic signed [PROD_W-1:0] prod;
    lane_sum_nxt = '0;
    for (int i = 0; i < ELEMS_PER_LANE; i++) begin
      xv   = {~x_nibs[i*NIB_W + NIB_W-1], x_nibs[i*NIB_W +: NIB_W-1]};
      yv   = {~y_nibs[i*NIB_W + NIB_W-1], y_nibs[i*NIB_W +: NIB_W-1]};
      prod = PROD_W'(xv) * PROD_W'(yv);
      lane_sum_nxt = lane_sum_nxt + LANE_SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_sum_r <= lane_sum_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/q4dp_merge.sv]
// Merge stage: sums the lane results, applies both scales, aligns the term.
// Depends on q4dp_pkg; fed by the q4dp_lane instances.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_merge
  import q4dp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        adv,
  input  wire logic signed [SCALE_W-1:0]   x_scale,
  input  wire logic signed [SCALE_W-1:0]   y_scale,
  input  wire lane_sum_vec_t               lane_sums,
  output logic signed [ACC_W-1:0]          term_r
);

  logic signed [SP_W-1:0]  sp1_r;
  logic signed [SP_W-1:0]  sp2_r;
  logic signed [DOT_W-1:0] dot2_r;
  logic signed [DOT_W-1:0] dot_nxt;
  logic signed [RAW_W-1:0] raw;

  // Lane merge
  always_comb begin
    dot_nxt = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      dot_nxt = dot_nxt + DOT_W'(signed'(lane_sums[l]));
    end
  end

  assign raw = RAW_W'(sp2_r) * RAW_W'(dot2_r);

  // Stage 1 scale product, stage 2 dot and scale, stage 3 aligned term
  always_ff @(posedge clk) begin
    if (adv) begin
      sp1_r  <= SP_W'(x_scale) * SP_W'(y_scale);
      sp2_r  <= sp1_r;
      dot2_r <= dot_nxt;
      term_r <= align_term(raw);
    end
  end

endmodule

`default_nettype wire

[sv/q4dp_accum.sv]
// Saturating 64-bit accumulator and result register.
// Depends on q4dp_pkg; term comes from q4dp_merge.
`timescale 1ns / 1ps
`default_nettype none

module q4dp_accum
  import q4dp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire stg_ctrl_t               s3,
  input  wire logic signed [ACC_W-1:0] term,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output out_item_t                    out_data
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r;
  logic signed [ACC_W:0]   wide;
  logic                    ovf_now;
  logic signed [ACC_W-1:0] sat_val;
  logic                    take;
  logic                    emit;

  // Add with one guard bit; clamp on sign disagreement
  assign wide    = {acc_r[ACC_W-1], acc_r} + {term[ACC_W-1], term};
  assign ovf_now = wide[ACC_W] ^ wide[ACC_W-1];
  assign sat_val = ovf_now ? (wide[ACC_W] ? ACC_MIN : ACC_MAX) : wide[ACC_W-1:0];
  assign take    = s3.vld && adv;
  assign emit    = take && s3.last;

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (take) begin
      if (s3.last) begin
        acc_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        acc_nxt = sat_val;
        ovf_nxt = ovf_r | ovf_now;
      end
    end
  end

  // Result register; adv guarantees it is free when a last item lands
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.dot_sum   <= sat_val;
      out_data_r.saturated <= ovf_r | ovf_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Closing a vector leaves a clean accumulator
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (acc_r == '0) && !ovf_r)
    else $error("accumulator not cleared after last block");

  // A result only appears after a last block was accumulated
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("result raised without a last block");

  // A clamped addition pins the sum at a rail and sets the sticky flag
  a_clamp_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !s3.last && ovf_now) |=> ((acc_r == ACC_MAX) || (acc_r == ACC_MIN)) && ovf_r)
    else $error("saturation did not clamp");

  // A last block never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[sv/block_int4_scaled_dot_product.sv]
// Top level of the int4 block scaled dot product: lanes, merge, accumulator.
// Depends on q4dp_pkg, q4dp_lane, q4dp_merge and q4dp_accum.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_item_t  (scales, nibbles, last flag)
//   out_     output     out_valid / out_stall out_item_t (dot_sum, saturated)
//
// One block pair is taken per cycle while in_stall is low; the four-stage
// pipeline (lanes, merge, scale multiply, accumulate) puts a vector's result
// in the output register when its last block pair reaches the accumulate stage.
// in_stall rises only while a last block waits at the accumulator and the
// output register still holds an untaken result; the whole pipeline holds.
// Synchronous active-low reset clears the accumulator, flags and valid bits.
`timescale 1ns / 1ps
`default_nettype none

module block_int4_scaled_dot_product
  import q4dp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic                    adv;
  stg_ctrl_t               s1_r, s2_r, s3_r;
  stg_ctrl_t               s1_nxt;
  logic [2*WORD_W-1:0]     x_all;
  logic [2*WORD_W-1:0]     y_all;
  lane_sum_vec_t           lane_sums;
  logic signed [ACC_W-1:0] term;

  // Global pipeline enable
  assign adv      = !(s3_r.vld && s3_r.last && out_valid && out_stall);
  assign in_stall = !adv;

  assign x_all = {in_data.x_nibbles_hi, in_data.x_nibbles_lo};
  assign y_all = {in_data.y_nibbles_hi, in_data.y_nibbles_lo};

  // Control pipeline
  assign s1_nxt.vld  = in_valid;
  assign s1_nxt.last = in_data.last_block;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  // Lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    q4dp_lane u_lane (
      .clk        (clk),
      .adv        (adv),
      .x_nibs     (x_all[l*LANE_IN_W +: LANE_IN_W]),
      .y_nibs     (y_all[l*LANE_IN_W +: LANE_IN_W]),
      .lane_sum_r (lane_sums[l])
    );
  end

  q4dp_merge u_merge (
    .clk       (clk),
    .adv       (adv),
    .x_scale   (in_data.x_scale),
    .y_scale   (in_data.y_scale),
    .lane_sums (lane_sums),
    .term_r    (term)
  );

  q4dp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s3        (s3_r),
    .term      (term),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
